// ===== rtl/sha512_pkg.sv =====
// Package: types, constants, rotate and message schedule functions for the SHA-512 engine.
package sha512_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned Rounds = 80;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last_word;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  digest_index;
    logic        last;
  } out_beat_t;

  localparam logic [63:0] ROUND_K [0:79] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam logic [63:0] INIT_H [0:7] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] sig0(input logic [63:0] x);
    sig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic logic [63:0] sig1(input logic [63:0] x);
    sig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

endpackage

// ===== rtl/sha512_sched_mem.sv =====
// Message schedule window: 16-entry memory with one registered read port.
module sha512_sched_mem (
  input  logic        clk,
  input  logic        we,
  input  logic [3:0]  waddr,
  input  logic [63:0] wdata,
  input  logic [3:0]  raddr,
  output logic [63:0] rdata
);
  logic [63:0] mem [0:15];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/sha512_hash_engine_unit.sv =====
// Top level of the streaming SHA-512 hash engine.
// A non-final word that does not fill a block is stored without leaving idle. The sixteenth
// word starts compression: load the working registers, then per round four schedule reads and
// one update, then add into the hash and check.
// A final word pads 1 or 2 blocks at one slot per cycle; the digest leaves as 8 strobed beats
// back to back; the receiver cannot stall. Throughput is set by the schedule read port.
// Reset (rst, synchronous): clears control, loads the initial hash, idles ready.
module sha512_hash_engine_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  sha512_pkg::in_beat_t  in_data,
  output logic                  strobe,
  output sha512_pkg::out_beat_t result
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PAD   = 8'b0000_0010,
    S_INIT  = 8'b0000_0100,
    S_RD    = 8'b0000_1000,
    S_RND   = 8'b0001_0000,
    S_ADD   = 8'b0010_0000,
    S_OUT   = 8'b0100_0000,
    S_CHK   = 8'b1000_0000
  } state_t;

  state_t      state;
  logic [63:0] hv [0:7];
  logic [63:0] va, vb, vc, vd, ve, vf, vg, vh;
  logic [3:0]  wpos;
  logic [6:0]  rnd;
  logic [2:0]  phase;
  logic [63:0] blen;
  logic        started;
  logic        finishing;
  logic        len_done;
  logic        len_here;
  logic        blen_placed;
  logic [2:0]  oidx;
  logic [63:0] w0, w1, w9, w14;

  logic        mwe;
  logic [3:0]  mwaddr, mraddr;
  logic [63:0] mwdata, mrdata;

  sha512_sched_mem u_mem (
    .clk(clk), .we(mwe), .waddr(mwaddr), .wdata(mwdata), .raddr(mraddr), .rdata(mrdata)
  );

  logic [3:0]  cnt;
  logic [63:0] keep, last_word_val, wt, t1, t2;
  logic        accept;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign cnt    = (in_data.byte_count > 4'd8) ? 4'd8 : in_data.byte_count;

  always_comb begin
    keep = (cnt == 4'd0) ? 64'd0 : ~({64{1'b1}} >> {cnt, 3'b000});
    last_word_val = (in_data.data_word & keep) |
                    ({56'd0, sha512_pkg::PAD_BYTE} << (7'd56 - {cnt[2:0], 3'b000}));
  end

  // Schedule read order per round: w[t-16], w[t-15], w[t-7], w[t-2].
  always_comb begin
    case (phase)
      3'd0:    mraddr = rnd[3:0];
      3'd1:    mraddr = rnd[3:0] + 4'd1;
      3'd2:    mraddr = rnd[3:0] + 4'd9;
      default: mraddr = rnd[3:0] + 4'd14;
    endcase
  end

  assign wt = (rnd < 7'd16) ? w0 : (w0 + sha512_pkg::sig0(w1) + w9 + sha512_pkg::sig1(w14));

  always_comb begin
    t1 = vh + (sha512_pkg::rotr(ve, 14) ^ sha512_pkg::rotr(ve, 18) ^ sha512_pkg::rotr(ve, 41))
         + ((ve & vf) ^ (~ve & vg)) + sha512_pkg::ROUND_K[rnd] + wt;
    t2 = (sha512_pkg::rotr(va, 28) ^ sha512_pkg::rotr(va, 34) ^ sha512_pkg::rotr(va, 39))
         + ((va & vb) ^ (va & vc) ^ (vb & vc));
  end

  always_comb begin
    mwe = 1'b0; mwaddr = wpos; mwdata = 64'd0;
    case (state)
      S_IDLE: begin
        mwe = accept;
        mwdata = (!in_data.last_word || cnt == 4'd8) ? in_data.data_word : last_word_val;
        mwaddr = started ? wpos : 4'd0;
      end
      S_PAD: begin
        // Marker first, then zeros; the length goes in slot 15 only if it fits this block.
        mwe = 1'b1;
        if (!len_done) mwdata = {sha512_pkg::PAD_BYTE, 56'd0};
        else if (wpos == 4'd15 && len_here) mwdata = blen;
        else mwdata = 64'd0;
      end
      S_RND: begin
        mwe = (rnd >= 7'd16);
        mwaddr = rnd[3:0];
        mwdata = wt;
      end
      default: mwe = 1'b0;
    endcase
  end

  // len_done here marks that the 0x80 marker is already placed.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; wpos <= '0; rnd <= '0; phase <= '0; blen <= '0;
      started <= 1'b0; finishing <= 1'b0; len_done <= 1'b0; len_here <= 1'b0;
      oidx <= '0; strobe <= 1'b0;
      for (int i = 0; i < 8; i++) hv[i] <= sha512_pkg::INIT_H[i];
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            logic [3:0]  np;
            logic [63:0] bl;
            np = (started ? wpos : 4'd0) + 4'd1;
            bl = started ? blen : 64'd0;
            if (!started) for (int i = 0; i < 8; i++) hv[i] <= sha512_pkg::INIT_H[i];
            started <= 1'b1;
            wpos <= np;
            len_here <= 1'b0;
            if (!in_data.last_word) begin
              blen <= bl + 64'd64;
              finishing <= 1'b0;
              if (np == 4'd0) state <= S_INIT;
            end else begin
              blen <= bl + {57'd0, cnt, 3'b000};
              finishing <= 1'b1;
              len_done <= (cnt != 4'd8);
              state <= (np == 4'd0) ? S_INIT : S_PAD;
            end
          end
        end
        S_PAD: begin
          // Any padding slot leaves the marker placed; the length fits only
          // if the marker was already in place when slot 14 came up.
          len_done <= 1'b1;
          if (wpos == 4'd14) len_here <= len_done;
          wpos <= wpos + 4'd1;
          if (wpos == 4'd15) begin
            state <= S_INIT;
          end
        end
        S_INIT: begin
          va <= hv[0]; vb <= hv[1]; vc <= hv[2]; vd <= hv[3];
          ve <= hv[4]; vf <= hv[5]; vg <= hv[6]; vh <= hv[7];
          rnd <= '0; phase <= '0; state <= S_RD;
        end
        S_RD: begin
          // Registered reads land in the cycle after their address.
          if (phase == 3'd1) w0 <= mrdata;
          if (phase == 3'd2) w1 <= mrdata;
          if (phase == 3'd3) w9 <= mrdata;
          phase <= phase + 3'd1;
          if (phase == 3'd3) state <= S_RND;
        end
        S_RND: begin
          vh <= vg; vg <= vf; vf <= ve; ve <= vd + t1;
          vd <= vc; vc <= vb; vb <= va; va <= t1 + t2;
          phase <= '0;
          if (rnd == 7'(sha512_pkg::Rounds - 1)) begin
            state <= S_ADD;
          end else begin
            rnd <= rnd + 7'd1;
            state <= S_RD;
          end
        end
        S_ADD: begin
          hv[0] <= hv[0] + va; hv[1] <= hv[1] + vb; hv[2] <= hv[2] + vc; hv[3] <= hv[3] + vd;
          hv[4] <= hv[4] + ve; hv[5] <= hv[5] + vf; hv[6] <= hv[6] + vg; hv[7] <= hv[7] + vh;
          state <= S_CHK;
        end
        S_CHK: begin
          if (!finishing) begin
            state <= S_IDLE;
          end else if (wpos == 4'd0 && blen_placed) begin
            oidx <= '0; state <= S_OUT;
          end else begin
            state <= S_PAD;
          end
        end
        S_OUT: begin
          strobe <= 1'b1;
          result.digest_word  <= hv[oidx];
          result.digest_index <= oidx;
          result.last         <= (oidx == 3'd7);
          oidx <= oidx + 3'd1;
          if (oidx == 3'd7) begin
            started <= 1'b0; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // w14 arrives in the cycle of the round update.
  assign w14 = mrdata;

  // Length slot written: set when padding wrote the length into entry 15 of a block.
  always_ff @(posedge clk) begin
    if (rst) blen_placed <= 1'b0;
    else if (state == S_IDLE) blen_placed <= 1'b0;
    else if (state == S_PAD && wpos == 4'd15 && len_here) blen_placed <= 1'b1;
  end

endmodule

// ===== rtl/sha512_checker.sv =====
// Port checker for the SHA-512 engine, bound to the top level.
module sha512_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  busy,
  input sha512_pkg::out_beat_t result,
  input logic                  strobe
);
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst) strobe |-> busy || result.last)
    else $error("strobe while idle");
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |=> strobe && result.digest_index == $past(result.digest_index) + 3'd1)
    else $error("digest beats not consecutive");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |=> !strobe)
    else $error("beat after last");
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |-> result.digest_index == 3'd7)
    else $error("last on wrong index");
endmodule

bind sha512_hash_engine_unit sha512_checker u_chk (
  .clk(clk), .rst(rst), .busy(busy), .result(result), .strobe(strobe)
);

// ===== tb/sv/sha512_hash_engine_unit_tb.sv =====
// Testbench for the streaming SHA-512 engine: random and directed messages vs a predictor.
module sha512_hash_engine_unit_tb;
  import sha512_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  in_beat_t  in_data = '0;
  logic      strobe;
  out_beat_t result;

  sha512_hash_engine_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_data(in_data), .strobe(strobe), .result(result)
  );

  always #5 clk = ~clk;

  // Predictor state: running hash, open block, message length.
  logic [63:0] pred_hash [8];
  logic [63:0] pred_block [16];
  int unsigned pred_pos;
  logic [63:0] pred_bits;
  bit          pred_open;

  in_beat_t    word_queue [$];
  out_beat_t   digest_queue [$];
  bit          failed = 1'b0;
  bit          quiet = 1'b0;     // no-idle stretch
  longint      cycle_count = 0;

  function automatic logic [63:0] ror(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  // Run the 80 rounds over the open block and fold into the hash.
  task automatic compress_open_block();
    logic [63:0] v [8];
    logic [63:0] w [80];
    logic [63:0] t1, t2;
    for (int t = 0; t < 80; t++) begin
      if (t < 16) w[t] = pred_block[t];
      else w[t] = w[t-16] + w[t-7]
                  + (ror(w[t-15], 1) ^ ror(w[t-15], 8) ^ (w[t-15] >> 7))
                  + (ror(w[t-2], 19) ^ ror(w[t-2], 61) ^ (w[t-2] >> 6));
    end
    for (int j = 0; j < 8; j++) v[j] = pred_hash[j];
    for (int t = 0; t < 80; t++) begin
      t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
      t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) pred_hash[j] += v[j];
  endtask

  task automatic append_word(logic [63:0] w);
    pred_block[pred_pos] = w;
    pred_pos = (pred_pos + 1) % 16;
    if (pred_pos == 0) compress_open_block();
  endtask

  // Advance the digest model by one accepted beat; queue the digest on a final word.
  task automatic absorb_word(in_beat_t b);
    int unsigned n;
    logic [63:0] keep;
    out_beat_t   d;
    if (!pred_open) begin
      for (int j = 0; j < 8; j++) pred_hash[j] = INIT_H[j];
      pred_pos = 0;
      pred_bits = '0;
      pred_open = 1'b1;
    end
    if (!b.last_word) begin
      pred_bits += 64;
      append_word(b.data_word);
    end else begin
      n = (b.byte_count > 8) ? 8 : b.byte_count;
      pred_bits += 64'(n * 8);
      if (n == 8) begin
        append_word(b.data_word);
        append_word({PAD_BYTE, 56'h0});
      end else begin
        keep = (n == 0) ? '0 : ~64'h0 << (64 - 8 * n);
        append_word((b.data_word & keep) | (64'(PAD_BYTE) << (56 - 8 * n)));
      end
      while (pred_pos != 14) append_word('0);
      append_word('0);
      append_word(pred_bits);
      for (int j = 0; j < 8; j++) begin
        d.digest_word = pred_hash[j];
        d.digest_index = 3'(j);
        d.last = (j == 7);
        digest_queue.push_back(d);
      end
      pred_open = 1'b0;
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Queue one message of nwords; the final beat gets the given byte count.
  task automatic queue_message(int nwords, logic [3:0] cnt, bit ones);
    in_beat_t b;
    for (int i = 0; i < nwords; i++) begin
      b.data_word = ones ? ~64'h0 : rand64();
      b.last_word = (i == nwords - 1);
      b.byte_count = b.last_word ? cnt : 4'($urandom_range(0, 15));
      word_queue.push_back(b);
    end
  endtask

  initial begin
    // Directed: empty message, full-ones and random words, every byte count,
    // saturating counts, and padding that spills into a second block.
    queue_message(1, 4'd0, 1'b0);
    queue_message(1, 4'd8, 1'b1);
    queue_message(1, 4'd15, 1'b1);
    queue_message(1, 4'd3, 1'b0);
    queue_message(2, 4'd9, 1'b0);
    queue_message(15, 4'd7, 1'b1);
    queue_message(14, 4'd8, 1'b0);
    for (int c = 0; c <= 8; c++) queue_message(1, 4'(c), 1'b0);
    // Random: mostly short messages, some spanning block boundaries.
    while (word_queue.size() < 360) begin
      if ($urandom_range(0, 9) == 0)
        queue_message($urandom_range(14, 40), 4'($urandom_range(0, 15)), 1'b0);
      else
        queue_message($urandom_range(1, 17), 4'($urandom_range(0, 15)), $urandom_range(0, 9) == 0);
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver: offer the head beat on start, dropping start at random outside a no-idle stretch; pop it when taken.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 2000 == 0) quiet <= ($urandom_range(0, 3) == 0);
    if (!rst) begin
      if (start && !busy) begin
        absorb_word(in_data);
        void'(word_queue.pop_front());
      end
      if (word_queue.size() > 0 && (quiet || $urandom_range(0, 99) >= 7)) begin
        start <= 1'b1;
        in_data <= word_queue[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare every strobed digest beat with the oldest expectation.
  always @(posedge clk) begin
    out_beat_t exp_beat;
    if (!rst && strobe) begin
      if (digest_queue.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, result);
        failed = 1'b1;
      end else begin
        exp_beat = digest_queue.pop_front();
        if (result.digest_word !== exp_beat.digest_word ||
            result.digest_index !== exp_beat.digest_index ||
            result.last !== exp_beat.last) begin
          $display("%0t: expected %h %0d %b, actual %h %0d %b", $time,
                   exp_beat.digest_word, exp_beat.digest_index, exp_beat.last,
                   result.digest_word, result.digest_index, result.last);
          failed = 1'b1;
        end
      end
    end
  end

  // End of run: drain expectations, then a short settle, bounded by a cycle limit.
  initial begin
    wait (!rst);
    fork
      begin
        wait (word_queue.size() == 0 && !start && digest_queue.size() == 0);
        repeat (1000) @(posedge clk);
      end
      wait (cycle_count > 2000000);
    join_any
    if (word_queue.size() != 0 || digest_queue.size() != 0) failed = 1'b1;
    if (!failed) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
